// ----- sv/owo_pkg.sv -----
// Shared types, codes and constants of the omni wheel odometry block.
// No dependencies.
package owo_pkg;

    localparam logic [31:0] CORDIC_GAIN_Q32 = 32'd2608131496;
    localparam logic [31:0] FWD_COEF_RST    = 32'd47114331;
    localparam logic [31:0] SIDE_COEF_RST   = 32'd27201459;
    localparam logic [31:0] TURN_COEF_RST   = 32'd44539575;

    localparam int VW = 38;
    localparam int AW = 71;

    typedef enum logic [1:0] {
        REG_FWD_COEF  = 2'd0,
        REG_SIDE_COEF = 2'd1,
        REG_TURN_COEF = 2'd2,
        REG_NONE      = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        OP_FWD  = 3'd0,
        OP_SIDE = 3'd1,
        OP_TURN = 3'd2,
        OP_GX   = 3'd3,
        OP_GY   = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COMB,
        ST_MSET,
        ST_MLO,
        ST_MHI,
        ST_MACC,
        ST_MWB,
        ST_PREROT,
        ST_CORDIC,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic       load_in;
        logic       comb;
        logic       mset;
        logic       mlo;
        logic       mhi;
        logic       macc;
        logic       mwb;
        logic       prerot;
        logic       cstep;
        logic       update;
        op_t        op;
        logic [4:0] cidx;
    } owo_cmd_t;

    typedef struct packed {
        logic out_busy;
    } owo_stat_t;

    function automatic logic [31:0] atan_units(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/owo_ctrl.sv -----
// Sequencer of the omni wheel odometry block: steps the datapath through
// deltas, shared multiplies and CORDIC iterations. Depends on owo_pkg.
module owo_ctrl
    import owo_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  owo_stat_t stat,
    output owo_cmd_t  cmd
);

    localparam int CW = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;

    state_t         state_reg, state_next;
    op_t            op_reg, op_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_FWD;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_COMB;
            end
            ST_COMB: begin
                op_next    = OP_FWD;
                state_next = ST_MSET;
            end
            ST_MSET:   state_next = ST_MLO;
            ST_MLO:    state_next = ST_MHI;
            ST_MHI:    state_next = ST_MACC;
            ST_MACC:   state_next = ST_MWB;
            ST_MWB: begin
                case (op_reg)
                    OP_FWD:  begin op_next = OP_SIDE; state_next = ST_MSET; end
                    OP_SIDE: begin op_next = OP_TURN; state_next = ST_MSET; end
                    OP_TURN: state_next = ST_PREROT;
                    OP_GX:   begin op_next = OP_GY; state_next = ST_MSET; end
                    default: state_next = ST_UPDATE;
                endcase
            end
            ST_PREROT: begin
                cnt_next   = '0;
                state_next = ST_CORDIC;
            end
            ST_CORDIC: begin
                if (cnt_reg == CW'(CORDIC_ITERATIONS - 1)) begin
                    op_next    = OP_GX;
                    state_next = ST_MSET;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_UPDATE: begin
                if (!stat.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd         = '0;
        cmd.op      = op_reg;
        cmd.cidx    = 5'(cnt_reg);
        s_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            ST_COMB:   cmd.comb   = 1'b1;
            ST_MSET:   cmd.mset   = 1'b1;
            ST_MLO:    cmd.mlo    = 1'b1;
            ST_MHI:    cmd.mhi    = 1'b1;
            ST_MACC:   cmd.macc   = 1'b1;
            ST_MWB:    cmd.mwb    = 1'b1;
            ST_PREROT: cmd.prerot = 1'b1;
            ST_CORDIC: cmd.cstep  = 1'b1;
            ST_UPDATE: cmd.update = !stat.out_busy;
            default:   cmd.comb   = 1'b0;
        endcase
    end

endmodule

// ----- sv/owo_datapath.sv -----
// Datapath of the omni wheel odometry block: coefficient registers, deltas,
// shared 32x32 multiplier, CORDIC rotator, accumulators and output register.
// Depends on owo_pkg.
module owo_datapath
    import owo_pkg::*;
#(
    parameter int ANGLE_WIDTH = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  owo_cmd_t           cmd,
    output owo_stat_t          stat,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic signed [31:0] s_angle_wheel0,
    input  logic signed [31:0] s_angle_wheel1,
    input  logic signed [31:0] s_angle_wheel2,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic [31:0]        m_heading,
    output logic               m_overflow
);

    localparam int DW = (ANGLE_WIDTH < 33) ? ANGLE_WIDTH : 33;

    logic [31:0] fwd_coef_reg, side_coef_reg, turn_coef_reg;
    logic signed [31:0] prev_reg [3];
    logic signed [32:0] d_reg [3];
    logic signed [34:0] cf_reg, cs_reg, ct_reg;
    logic [VW-1:0] mag_reg;
    logic neg_reg, sh16_reg;
    logic [31:0] coef_reg;
    logic [63:0] prod_reg;
    logic [AW-1:0] acc_reg;
    logic signed [VW-1:0] fwd_reg, side_reg, cx_reg, cy_reg, gx_reg, gy_reg;
    logic signed [32:0] cz_reg;
    logic [31:0] turn_reg;
    logic signed [31:0] x_reg, y_reg;
    logic [31:0] yaw_reg;
    logic m_valid_reg;
    logic signed [31:0] ox_reg, oy_reg;
    logic [31:0] oh_reg;
    logic ovf_reg;

    logic signed [31:0] ang [3];
    logic signed [32:0] d_next [3];
    logic signed [VW-1:0] src, r_mag, r_res, xs, ys;
    logic [31:0] coef_sel, atan_v;
    logic signed [33:0] z_ext;
    logic signed [38:0] nx, ny;
    logic ovf_x, ovf_y;
    logic signed [31:0] sx, sy;

    assign ang[0] = s_angle_wheel0;
    assign ang[1] = s_angle_wheel1;
    assign ang[2] = s_angle_wheel2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic signed [32:0] diff;
            diff      = 33'(ang[i]) - 33'(prev_reg[i]);
            d_next[i] = 33'($signed(diff[DW-1:0]));
        end
    end

    always_comb begin
        case (cmd.op)
            OP_FWD:  begin src = VW'(cf_reg); coef_sel = fwd_coef_reg;  end
            OP_SIDE: begin src = VW'(cs_reg); coef_sel = side_coef_reg; end
            OP_TURN: begin src = VW'(ct_reg); coef_sel = turn_coef_reg; end
            OP_GX:   begin src = cx_reg;      coef_sel = CORDIC_GAIN_Q32; end
            default: begin src = cy_reg;      coef_sel = CORDIC_GAIN_Q32; end
        endcase
    end

    assign r_mag  = sh16_reg ? $signed(acc_reg[16 +: VW]) : $signed(acc_reg[32 +: VW]);
    assign r_res  = neg_reg ? -r_mag : r_mag;
    assign xs     = cx_reg >>> cmd.cidx;
    assign ys     = cy_reg >>> cmd.cidx;
    assign atan_v = atan_units(cmd.cidx);
    assign z_ext  = 34'($signed(yaw_reg));

    assign nx    = 39'(x_reg) + 39'(gx_reg);
    assign ny    = 39'(y_reg) + 39'(gy_reg);
    assign ovf_x = (nx > 39'sd2147483647) || (nx < -39'sd2147483648);
    assign ovf_y = (ny > 39'sd2147483647) || (ny < -39'sd2147483648);
    assign sx    = ovf_x ? (nx[38] ? 32'sh80000000 : 32'sh7fffffff) : nx[31:0];
    assign sy    = ovf_y ? (ny[38] ? 32'sh80000000 : 32'sh7fffffff) : ny[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_coef_reg  <= FWD_COEF_RST;
            side_coef_reg <= SIDE_COEF_RST;
            turn_coef_reg <= TURN_COEF_RST;
            for (int i = 0; i < 3; i++) prev_reg[i] <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            yaw_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (reg_idx_t'(cfg_index))
                    REG_FWD_COEF:  fwd_coef_reg  <= cfg_data;
                    REG_SIDE_COEF: side_coef_reg <= cfg_data;
                    REG_TURN_COEF: turn_coef_reg <= cfg_data;
                    default:       fwd_coef_reg  <= fwd_coef_reg;
                endcase
            end
            if (cmd.load_in) begin
                for (int i = 0; i < 3; i++) prev_reg[i] <= ang[i];
            end
            if (cmd.update) begin
                x_reg       <= sx;
                y_reg       <= sy;
                yaw_reg     <= yaw_reg - turn_reg;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            for (int i = 0; i < 3; i++) d_reg[i] <= d_next[i];
        end
        if (cmd.comb) begin
            cf_reg <= 35'(d_reg[0]) - 35'(d_reg[2]);
            cs_reg <= (35'(d_reg[1]) <<< 1) - 35'(d_reg[0]) - 35'(d_reg[2]);
            ct_reg <= 35'(d_reg[0]) + 35'(d_reg[1]) + 35'(d_reg[2]);
        end
        if (cmd.mset) begin
            neg_reg  <= src[VW-1];
            mag_reg  <= src[VW-1] ? VW'(-src) : VW'(src);
            coef_reg <= coef_sel;
            sh16_reg <= (cmd.op == OP_TURN);
        end
        if (cmd.mlo) prod_reg <= mag_reg[31:0] * coef_reg;
        if (cmd.mhi) begin
            prod_reg <= 32'(mag_reg[VW-1:32]) * coef_reg;
            acc_reg  <= AW'(prod_reg) + (sh16_reg ? AW'(1) << 15 : AW'(1) << 31);
        end
        if (cmd.macc) acc_reg <= acc_reg + (AW'(prod_reg) << 32);
        if (cmd.mwb) begin
            case (cmd.op)
                OP_FWD:  fwd_reg  <= r_res;
                OP_SIDE: side_reg <= r_res;
                OP_TURN: turn_reg <= r_res[31:0];
                OP_GX:   gx_reg   <= r_res;
                default: gy_reg   <= r_res;
            endcase
        end
        if (cmd.prerot) begin
            if (z_ext > 34'sh40000000) begin
                cz_reg <= 33'(z_ext - 34'sh80000000);
                cx_reg <= -fwd_reg;
                cy_reg <= -side_reg;
            end else if (z_ext < -34'sh40000000) begin
                cz_reg <= 33'(z_ext + 34'sh80000000);
                cx_reg <= -fwd_reg;
                cy_reg <= -side_reg;
            end else begin
                cz_reg <= 33'(z_ext);
                cx_reg <= fwd_reg;
                cy_reg <= side_reg;
            end
        end
        if (cmd.cstep) begin
            if (!cz_reg[32]) begin
                cx_reg <= cx_reg - ys;
                cy_reg <= cy_reg + xs;
                cz_reg <= cz_reg - 33'(atan_v);
            end else begin
                cx_reg <= cx_reg + ys;
                cy_reg <= cy_reg - xs;
                cz_reg <= cz_reg + 33'(atan_v);
            end
        end
        if (cmd.update) begin
            ox_reg  <= sx;
            oy_reg  <= sy;
            oh_reg  <= yaw_reg - turn_reg;
            ovf_reg <= ovf_x | ovf_y;
        end
    end

    assign stat.out_busy = m_valid_reg & ~m_ready;
    assign m_valid    = m_valid_reg;
    assign m_pos_x    = ox_reg;
    assign m_pos_y    = oy_reg;
    assign m_heading  = oh_reg;
    assign m_overflow = ovf_reg;

endmodule

// ----- sv/omni_wheel_odometry.sv -----
// An input transaction passes the deltas, three coefficient multiplies, the CORDIC
// rotator at one CORDIC iteration per cycle and two gain multiplies: five passes
// through the shared 32x32 multiplier. One item at a time: no new input transaction
// is taken until the previous result is in the output register. A finished result
// waits in the output register while the next item is taken. Synchronous active-low
// reset restores coefficients and clears the control state, angles, pose and valid.
module omni_wheel_odometry
    import owo_pkg::*;
#(
    parameter int ANGLE_WIDTH       = 32,
    parameter int CORDIC_ITERATIONS = 24
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_angle_wheel0,
    input  logic signed [31:0] s_angle_wheel1,
    input  logic signed [31:0] s_angle_wheel2,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_pos_x,
    output logic signed [31:0] m_pos_y,
    output logic [31:0]        m_heading,
    output logic               m_overflow
);

    owo_cmd_t  cmd;
    owo_stat_t stat;

    assign cfg_ready = 1'b1;

    owo_ctrl #(
        .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    owo_datapath #(
        .ANGLE_WIDTH(ANGLE_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_angle_wheel0 (s_angle_wheel0),
        .s_angle_wheel1 (s_angle_wheel1),
        .s_angle_wheel2 (s_angle_wheel2),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pos_x        (m_pos_x),
        .m_pos_y        (m_pos_y),
        .m_heading      (m_heading),
        .m_overflow     (m_overflow)
    );

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the omni wheel odometry block: directed and random ticks
// through valid/ready channels, checked against a built-in dead-reckoning predictor.
// Depends on owo_pkg and omni_wheel_odometry.
`timescale 1ns / 1ps

module testbench;
    import owo_pkg::*;

    typedef struct {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [31:0]        heading;
        logic               overflow;
    } pose_t;

    class pose_scoreboard;
        logic [31:0]        coef[3];
        logic signed [31:0] last_angle[3];
        logic signed [31:0] x_pos, y_pos;
        logic [31:0]        yaw;
        longint             atan_tab[24];
        pose_t              pending_poses[$];
        int                 errors;

        function new();
            atan_tab = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                         10679838, 5340245, 2670163, 1335087, 667544, 333772,
                         166886, 83443, 41722, 20861, 10430, 5215,
                         2608, 1304, 652, 326, 163, 81};
            coef = '{FWD_COEF_RST, SIDE_COEF_RST, TURN_COEF_RST};
            last_angle = '{0, 0, 0};
            x_pos = 0;
            y_pos = 0;
            yaw = 0;
            errors = 0;
        endfunction

        function void set_coef(reg_idx_t idx, logic [31:0] val);
            if (idx != REG_NONE) coef[idx] = val;
        endfunction

        function longint scale_round(longint v, logic [31:0] c, int sh);
            longint unsigned mag, hi, lo, r, cc;
            bit neg;
            neg = v < 0;
            mag = neg ? -v : v;
            cc = c;
            hi = mag >> 32;
            lo = mag & 64'hFFFF_FFFF;
            r = ((hi * cc) << (32 - sh)) + ((lo * cc + (64'd1 << (sh - 1))) >> sh);
            return neg ? -longint'(r) : longint'(r);
        endfunction

        function logic signed [31:0] clamp32(longint v, ref bit ovf);
            if (v > 64'sd2147483647) begin
                ovf = 1;
                return 32'sh7FFF_FFFF;
            end
            if (v < -64'sd2147483648) begin
                ovf = 1;
                return 32'sh8000_0000;
            end
            return v[31:0];
        endfunction

        function void note_tick(logic signed [31:0] a0, logic signed [31:0] a1,
                                logic signed [31:0] a2);
            logic signed [31:0] t;
            logic signed [31:0] a[3];
            longint d[3];
            longint fwd, side, turn, x, y, z, xs, ys;
            bit ovf;
            pose_t p;
            a = '{a0, a1, a2};
            for (int i = 0; i < 3; i++) begin
                t = a[i] - last_angle[i];
                d[i] = t;
                last_angle[i] = a[i];
            end
            fwd = scale_round(d[0] - d[2], coef[REG_FWD_COEF], 32);
            side = scale_round(2 * d[1] - d[0] - d[2], coef[REG_SIDE_COEF], 32);
            turn = scale_round(d[0] + d[1] + d[2], coef[REG_TURN_COEF], 16);
            x = fwd;
            y = side;
            t = yaw;
            z = t;
            if (z > 64'sd1073741824) begin
                z = z - 64'sd2147483648;
                x = -x;
                y = -y;
            end else if (z < -64'sd1073741824) begin
                z = z + 64'sd2147483648;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_tab[i];
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_tab[i];
                end
            end
            x = scale_round(x, CORDIC_GAIN_Q32, 32);
            y = scale_round(y, CORDIC_GAIN_Q32, 32);
            ovf = 0;
            x_pos = clamp32(longint'(x_pos) + x, ovf);
            y_pos = clamp32(longint'(y_pos) + y, ovf);
            yaw = yaw - turn[31:0];
            p.pos_x = x_pos;
            p.pos_y = y_pos;
            p.heading = yaw;
            p.overflow = ovf;
            pending_poses.push_back(p);
        endfunction

        function void check_pose(logic signed [31:0] px, logic signed [31:0] py,
                                 logic [31:0] hd, logic ov);
            pose_t e;
            if (pending_poses.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h heading=%h overflow=%b",
                         $time, px, py, hd, ov);
                errors++;
                return;
            end
            e = pending_poses.pop_front();
            if (px !== e.pos_x) begin
                $display("%0t: pos_x expected %h actual %h", $time, e.pos_x, px);
                errors++;
            end
            if (py !== e.pos_y) begin
                $display("%0t: pos_y expected %h actual %h", $time, e.pos_y, py);
                errors++;
            end
            if (hd !== e.heading) begin
                $display("%0t: heading expected %h actual %h", $time, e.heading, hd);
                errors++;
            end
            if (ov !== e.overflow) begin
                $display("%0t: overflow expected %b actual %b", $time, e.overflow, ov);
                errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    reg_idx_t           cfg_index;
    logic [31:0]        cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic signed [31:0] s_angle_wheel0;
    logic signed [31:0] s_angle_wheel1;
    logic signed [31:0] s_angle_wheel2;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_pos_x;
    logic signed [31:0] m_pos_y;
    logic [31:0]        m_heading;
    logic               m_overflow;

    pose_scoreboard     sb;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    bit                 hold_req;
    int                 quiet_cycles;
    logic signed [31:0] wheel[3];

    omni_wheel_odometry DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_angle_wheel0 (s_angle_wheel0),
        .s_angle_wheel1 (s_angle_wheel1),
        .s_angle_wheel2 (s_angle_wheel2),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pos_x        (m_pos_x),
        .m_pos_y        (m_pos_y),
        .m_heading      (m_heading),
        .m_overflow     (m_overflow)
    );

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    task automatic send_tick(logic signed [31:0] a0, logic signed [31:0] a1,
                             logic signed [31:0] a2);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_angle_wheel0 <= a0;
        s_angle_wheel1 <= a1;
        s_angle_wheel2 <= a2;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_tick(a0, a1, a2);
        wheel = '{a0, a1, a2};
    endtask

    task automatic write_coef(reg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_coef(idx, val);
    endtask

    task automatic set_coefs(logic [31:0] f, logic [31:0] s, logic [31:0] t);
        write_coef(REG_FWD_COEF, f);
        write_coef(REG_SIDE_COEF, s);
        write_coef(REG_TURN_COEF, t);
        write_coef(REG_NONE, $urandom);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (sb.pending_poses.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic random_ticks(int n);
        logic signed [31:0] a[3];
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < 3; i++) begin
                if ($urandom_range(99) < 80)
                    a[i] = wheel[i] + $signed($urandom_range(32'h80000)) - 32'sh40000;
                else
                    a[i] = $urandom;
            end
            send_tick(a[0], a[1], a[2]);
        end
    endtask

    // receiver: check, then pick the next ready
    initial begin
        int hold_cnt;
        hold_cnt = 0;
        m_ready = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) sb.check_pose(m_pos_x, m_pos_y, m_heading, m_overflow);
            if (hold_req) begin
                hold_req = 0;
                hold_cnt = 500;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_ready <= 0;
            end else begin
                m_ready <= ($urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;
            end
        end
    end

    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= 5000) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 0;
        wheel = '{0, 0, 0};
        aresetn = 0;
        cfg_valid = 0;
        cfg_index = REG_FWD_COEF;
        cfg_data = 0;
        s_valid = 0;
        s_angle_wheel0 = 0;
        s_angle_wheel1 = 0;
        s_angle_wheel2 = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_tick(0, 0, 0);
        send_tick(32'sh10000, 0, -32'sh10000);
        send_tick(32'sh10000, 32'sh20000, -32'sh10000);
        send_tick(32'sh30000, 32'sh30000, 32'sh0);
        send_tick(32'sh7FFF_FFFF, 0, 0);
        send_tick(32'sh8000_0000, 32'sh7FFF_FFFF, 0);
        send_tick(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_tick(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_tick(-1, -1, -1);
        drain();

        // saturate the position and wrap the heading
        set_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (int k = 0; k < 8; k++) begin
            send_tick(32'sh7FFF_FFFF, 32'sh4000_0000, 32'sh8000_0001);
            send_tick(32'sh8000_0000, 32'shC000_0000, 32'sh7FFF_FFFF);
        end
        drain();
        set_coefs(0, 0, 0);
        send_tick(32'sh1234_5678, -32'sh1234_5678, 32'sh5555_5555);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_coefs(FWD_COEF_RST, SIDE_COEF_RST, TURN_COEF_RST);
                1: set_coefs($urandom, $urandom, $urandom);
                2: set_coefs($urandom_range(32'h0800_0000), $urandom_range(32'h0800_0000),
                             $urandom_range(32'h0400_0000));
                default: set_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            endcase
            for (int mode = 0; mode < 4; mode++) begin
                send_idle_pct = (mode == 1) ? 58 : (mode == 3) ? 37 : 0;
                recv_stall_pct = (mode == 2) ? 58 : (mode == 3) ? 37 : 0;
                if (ph == 1 && mode == 0) hold_req = 1;
                random_ticks(58);
            end
            drain();
        end

        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();
        if (sb.errors == 0 && sb.pending_poses.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
